// File: rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants for the ring FIFO with peek: element and ring
// sizes, field widths, command codes and the structs passed between blocks.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam int SLOT_COUNT    = 256;
	localparam int ELEMENT_WIDTH = 32;
	localparam int SLOT_ADDR_W   = $clog2(SLOT_COUNT);

	localparam int CMD_W  = 3;
	localparam int DATA_W = 32;
	localparam int AMT_W  = 8;
	localparam int POS_W  = 8;
	localparam int CAP_W  = 9;

	// Largest usable ring: limited by the 8-bit positions and by the store.
	localparam int CAP_TOP = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
	localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(CAP_TOP);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = '0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH     = 3'd0,
		CMD_PULL     = 3'd1,
		CMD_PEEK     = 3'd2,
		CMD_ADV_READ = 3'd3,
		CMD_ADV_WRIT = 3'd4,
		CMD_CLEAR    = 3'd5
	} command_t;

	typedef struct packed {
		logic                     we;
		logic [SLOT_ADDR_W-1:0]   waddr;
		logic [ELEMENT_WIDTH-1:0] wdata;
		logic                     re;
		logic [SLOT_ADDR_W-1:0]   raddr;
	} ram_req_t;

	typedef struct packed {
		logic             is_read;
		logic             accepted;
		logic [POS_W-1:0] occupancy;
		logic [POS_W-1:0] free_slots;
		logic             overflow_seen;
	} res_info_t;

endpackage

// File: rtl/rfp_cmd_if.sv
// ----------------------------------------------------------------------------
// rfp_cmd_if
// Command channel of the ring FIFO: valid/ready handshake with the command
// item (command code, element to push, amount).
// ----------------------------------------------------------------------------
interface rfp_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [rfp_pkg::CMD_W-1:0]     command;
	logic [rfp_pkg::DATA_W-1:0]    push_data;
	logic [rfp_pkg::AMT_W-1:0]     amount;

	modport source (output valid, command, push_data, amount, input ready);
	modport sink (input valid, command, push_data, amount, output ready);
endinterface

// File: rtl/rfp_res_if.sv
// ----------------------------------------------------------------------------
// rfp_res_if
// Result channel of the ring FIFO: valid/ready handshake with one result item
// per command.
// ----------------------------------------------------------------------------
interface rfp_res_if;
	logic                          valid;
	logic                          ready;
	logic [rfp_pkg::DATA_W-1:0]    read_data;
	logic                          accepted;
	logic [rfp_pkg::POS_W-1:0]     occupancy;
	logic [rfp_pkg::POS_W-1:0]     free_slots;
	logic                          overflow_seen;

	modport source (output valid, read_data, accepted, occupancy, free_slots,
		overflow_seen, input ready);
	modport sink (input valid, read_data, accepted, occupancy, free_slots,
		overflow_seen, output ready);
endinterface

// File: rtl/rfp_ram.sv
// ----------------------------------------------------------------------------
// rfp_ram
// Generic single-write, single-read RAM with a registered read port. The read
// data holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module rfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/rfp_ctrl.sv
// ----------------------------------------------------------------------------
// rfp_ctrl
// Pointer and flag state of the ring. Decodes an accepted command, updates the
// read and write positions and the overflow mark, drives the slot memory and
// registers the result fields for the output stage.
// ----------------------------------------------------------------------------
module rfp_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [rfp_pkg::CMD_W-1:0]       command,
	input  logic [rfp_pkg::DATA_W-1:0]      push_data,
	input  logic [rfp_pkg::AMT_W-1:0]       amount,
	input  logic                            cfg_we,
	input  logic [rfp_pkg::CAP_W-1:0]       cfg_capacity,
	output logic [rfp_pkg::CAP_W-1:0]       capacity_q,
	output rfp_pkg::ram_req_t               ram_req,
	output rfp_pkg::res_info_t              info_s1
);

	logic [rfp_pkg::POS_W-1:0] rd_pos_q, wr_pos_q, rd_pos_n, wr_pos_n;
	logic                      ovf_q, ovf_n;
	logic [rfp_pkg::CAP_W-1:0] cap;
	logic [rfp_pkg::POS_W-1:0] occ_cur, occ_new;
	logic                      amt_ok;
	rfp_pkg::res_info_t        info_n;

	// Position plus distance, both below the capacity, wrapped once.
	function automatic logic [rfp_pkg::POS_W-1:0] wrap_add(
		input logic [rfp_pkg::POS_W-1:0] pos,
		input logic [rfp_pkg::POS_W-1:0] inc,
		input logic [rfp_pkg::CAP_W-1:0] cap_v
	);
		logic [rfp_pkg::CAP_W-1:0] sum;
		sum = {1'b0, pos} + {1'b0, inc};
		if (sum >= cap_v) begin
			sum = sum - cap_v;
		end
		return sum[rfp_pkg::POS_W-1:0];
	endfunction

	function automatic logic [rfp_pkg::POS_W-1:0] held(
		input logic [rfp_pkg::POS_W-1:0] wp,
		input logic [rfp_pkg::POS_W-1:0] rp,
		input logic [rfp_pkg::CAP_W-1:0] cap_v
	);
		logic [rfp_pkg::CAP_W-1:0] diff;
		diff = {1'b0, wp} - {1'b0, rp};
		if (wp < rp) begin
			diff = diff + cap_v;
		end
		return diff[rfp_pkg::POS_W-1:0];
	endfunction

	// Out-of-range register values are saturated into the usable range.
	always_comb begin
		if (capacity_q < rfp_pkg::CAP_MIN) begin
			cap = rfp_pkg::CAP_MIN;
		end else if (capacity_q > rfp_pkg::CAP_MAX) begin
			cap = rfp_pkg::CAP_MAX;
		end else begin
			cap = capacity_q;
		end
	end

	assign occ_cur = held(wr_pos_q, rd_pos_q, cap);
	assign amt_ok  = ({1'b0, amount} < cap);

	always_comb begin
		rd_pos_n       = rd_pos_q;
		wr_pos_n       = wr_pos_q;
		ovf_n          = ovf_q;
		ram_req.we     = 1'b0;
		ram_req.waddr  = rfp_pkg::SLOT_ADDR_W'(wr_pos_q);
		ram_req.wdata  = rfp_pkg::ELEMENT_WIDTH'(push_data);
		ram_req.re     = 1'b0;
		ram_req.raddr  = rfp_pkg::SLOT_ADDR_W'(rd_pos_q);
		info_n.is_read  = 1'b0;
		info_n.accepted = 1'b0;
		case (rfp_pkg::command_t'(command))
			rfp_pkg::CMD_PUSH: begin
				// One slot stays spare, so full means capacity minus one held.
				if ({1'b0, occ_cur} != cap - rfp_pkg::CAP_W'(1)) begin
					ram_req.we      = accept;
					wr_pos_n        = wrap_add(wr_pos_q, rfp_pkg::POS_W'(1), cap);
					info_n.accepted = 1'b1;
				end else begin
					ovf_n = 1'b1;
				end
			end
			rfp_pkg::CMD_PULL: begin
				if (occ_cur != '0) begin
					ram_req.re      = accept;
					rd_pos_n        = wrap_add(rd_pos_q, rfp_pkg::POS_W'(1), cap);
					info_n.is_read  = 1'b1;
					info_n.accepted = 1'b1;
				end
			end
			rfp_pkg::CMD_PEEK: begin
				if (amt_ok) begin
					ram_req.re      = accept;
					ram_req.raddr   = rfp_pkg::SLOT_ADDR_W'(wrap_add(rd_pos_q, amount, cap));
					info_n.is_read  = 1'b1;
					info_n.accepted = 1'b1;
				end
			end
			rfp_pkg::CMD_ADV_READ: begin
				if (amt_ok) begin
					rd_pos_n        = wrap_add(rd_pos_q, amount, cap);
					info_n.accepted = 1'b1;
				end
			end
			rfp_pkg::CMD_ADV_WRIT: begin
				if (amt_ok) begin
					wr_pos_n        = wrap_add(wr_pos_q, amount, cap);
					info_n.accepted = 1'b1;
				end
			end
			rfp_pkg::CMD_CLEAR: begin
				rd_pos_n        = '0;
				wr_pos_n        = '0;
				ovf_n           = 1'b0;
				info_n.accepted = 1'b1;
			end
			default: begin
			end
		endcase
		occ_new              = held(wr_pos_n, rd_pos_n, cap);
		info_n.occupancy     = occ_new;
		info_n.free_slots    = rfp_pkg::POS_W'(cap - rfp_pkg::CAP_W'(1) - {1'b0, occ_new});
		info_n.overflow_seen = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= rfp_pkg::CAP_RESET;
			rd_pos_q   <= '0;
			wr_pos_q   <= '0;
			ovf_q      <= 1'b0;
		end else if (cfg_we) begin
			// A new capacity empties the ring; the overflow mark is kept.
			capacity_q <= cfg_capacity;
			rd_pos_q   <= '0;
			wr_pos_q   <= '0;
		end else if (accept) begin
			rd_pos_q <= rd_pos_n;
			wr_pos_q <= wr_pos_n;
			ovf_q    <= ovf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info_n;
		end
	end

endmodule

// File: rtl/rfp_out.sv
// ----------------------------------------------------------------------------
// rfp_out
// Output stage. Joins the registered result fields with the slot memory read
// data and holds the result item until the consumer takes it.
// ----------------------------------------------------------------------------
module rfp_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  rfp_pkg::res_info_t                  info_s1,
	input  logic [rfp_pkg::ELEMENT_WIDTH-1:0]   rdata,
	output logic                                in_ready,
	rfp_res_if.source                           res
);

	logic valid_s1;
	logic res_valid_q;
	logic s1_move;

	// The memory read data only changes on a new item, so it is safe to
	// sample it whenever the first stage moves on.
	assign s1_move  = valid_s1 && (!res_valid_q || res.ready);
	assign in_ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res.read_data     <= info_s1.is_read ? rfp_pkg::DATA_W'(rdata) : '0;
			res.accepted      <= info_s1.accepted;
			res.occupancy     <= info_s1.occupancy;
			res.free_slots    <= info_s1.free_slots;
			res.overflow_seen <= info_s1.overflow_seen;
		end
	end

	assign res.valid = res_valid_q;

endmodule

// File: rtl/ring_fifo_with_peek.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_peek
// Ring-buffer FIFO of 32-bit elements with push, pull, peek at an offset,
// pointer advance and clear commands, and a sticky overflow flag. It takes one
// command item per clock cycle while the result side is not stalled, and
// returns one result item per command, registered first with the read port
// of the slot memory and then in the output stage. The slot memory is not
// cleared after reset, so the block is ready to take commands straight away.
// One slot is always kept spare, so a ring of capacity N holds N-1 elements.
// Writing the capacity register empties the ring.
// ----------------------------------------------------------------------------
module ring_fifo_with_peek (
	input  logic                                 clk,
	input  logic                                 arst_n,
	rfp_cmd_if.sink                              cmd,
	rfp_res_if.source                            res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rfp_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [rfp_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [rfp_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	logic                                in_ready;
	logic                                accept;
	logic                                reg_sel;
	logic                                cfg_we;
	logic [rfp_pkg::CAP_W-1:0]           capacity_q;
	logic [rfp_pkg::ELEMENT_WIDTH-1:0]   rdata;
	rfp_pkg::ram_req_t                   ram_req;
	rfp_pkg::res_info_t                  info_s1;

	assign accept    = cmd.valid && in_ready;
	assign cmd.ready = in_ready;

	assign reg_sel = (paddr[rfp_pkg::CFG_ADDR_W-1:2] == rfp_pkg::REG_CAPACITY);
	assign cfg_we  = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? rfp_pkg::CFG_DATA_W'(capacity_q) : '0;

	rfp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (cmd.command),
		.push_data    (cmd.push_data),
		.amount       (cmd.amount),
		.cfg_we       (cfg_we),
		.cfg_capacity (pwdata[rfp_pkg::CAP_W-1:0]),
		.capacity_q   (capacity_q),
		.ram_req      (ram_req),
		.info_s1      (info_s1)
	);

	rfp_ram #(
		.WIDTH (rfp_pkg::ELEMENT_WIDTH),
		.DEPTH (rfp_pkg::SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	rfp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.info_s1  (info_s1),
		.rdata    (rdata),
		.in_ready (in_ready),
		.res      (res)
	);

endmodule

// File: rtl/rfp_chk.sv
// ----------------------------------------------------------------------------
// rfp_chk
// Port-level checks for the ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module rfp_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [rfp_pkg::DATA_W-1:0]    read_data,
	input  logic                          accepted,
	input  logic [rfp_pkg::POS_W-1:0]     occupancy,
	input  logic [rfp_pkg::POS_W-1:0]     free_slots
);

	// A result item waiting for the consumer is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	// Occupancy and free space never add up to more than 255 slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, occupancy} + {1'b0, free_slots}) <= 9'd255)
		else $error("occupancy and free space exceed the ring");

	// A refused command never returns data.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !accepted |-> read_data == '0)
		else $error("refused command returned data");

	// A ring with no free slots is never reported as empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && free_slots == '0 |-> occupancy != '0)
		else $error("ring reported both empty and full");

endmodule

bind ring_fifo_with_peek rfp_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.read_data  (res.read_data),
	.accepted   (res.accepted),
	.occupancy  (res.occupancy),
	.free_slots (res.free_slots)
);

// File: tb/tb_ring_fifo_with_peek.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_fifo_with_peek
// Self-checking testbench for the ring FIFO with peek. Commands are sent over
// the command channel with random gaps and the results are taken with random
// stalls. A model of the ring inside the testbench predicts each result, and
// every result is compared field by field. The capacity register is rewritten
// between phases over the configuration port.
// ----------------------------------------------------------------------------
module tb_ring_fifo_with_peek;
	import rfp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CMD_W-1:0] CMD_RESERVED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RESERVED_7 = 3'd7;
	localparam logic [CFG_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] push_data;
		logic [AMT_W-1:0]  amount;
	} fifo_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              accepted;
		logic [POS_W-1:0]  occupancy;
		logic [POS_W-1:0]  free_slots;
		logic              overflow_seen;
	} fifo_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	rfp_cmd_if cmd_ch ();
	rfp_res_if res_ch ();

	ring_fifo_with_peek u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Model of the ring
	logic [DATA_W-1:0] slot_image [0:255];
	int                read_ptr;
	int                write_ptr;
	logic              overflow_flag;
	logic [CAP_W-1:0]  capacity_reg;

	fifo_result_t pending_results [$];
	int           mismatch_count;
	int           cycle_count;
	int           receiver_hold;
	bit           no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int effective_capacity();
		int c;
		c = capacity_reg;
		if (c < CAP_MIN) c = CAP_MIN;
		if (c > CAP_TOP) c = CAP_TOP;
		return c;
	endfunction

	function automatic int ring_occupancy(input int cap);
		return (write_ptr + cap - read_ptr) % cap;
	endfunction

	function automatic fifo_result_t apply_command(input fifo_cmd_t c);
		fifo_result_t r;
		int cap;
		int held;
		cap = effective_capacity();
		held = ring_occupancy(cap);
		r = '0;
		case (c.command)
			CMD_PUSH: begin
				if (held < cap - 1) begin
					slot_image[write_ptr] = c.push_data;
					write_ptr = (write_ptr + 1) % cap;
					r.accepted = 1'b1;
				end else begin
					overflow_flag = 1'b1;
				end
			end
			CMD_PULL: begin
				if (held != 0) begin
					r.read_data = slot_image[read_ptr];
					read_ptr = (read_ptr + 1) % cap;
					r.accepted = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (c.amount < cap) begin
					r.read_data = slot_image[(read_ptr + c.amount) % cap];
					r.accepted = 1'b1;
				end
			end
			CMD_ADV_READ: begin
				if (c.amount < cap) begin
					read_ptr = (read_ptr + c.amount) % cap;
					r.accepted = 1'b1;
				end
			end
			CMD_ADV_WRIT: begin
				if (c.amount < cap) begin
					write_ptr = (write_ptr + c.amount) % cap;
					r.accepted = 1'b1;
				end
			end
			CMD_CLEAR: begin
				read_ptr = 0;
				write_ptr = 0;
				overflow_flag = 1'b0;
				r.accepted = 1'b1;
			end
			default: ;
		endcase
		held = ring_occupancy(cap);
		r.occupancy = POS_W'(held);
		r.free_slots = POS_W'(cap - 1 - held);
		r.overflow_seen = overflow_flag;
		return r;
	endfunction

	function automatic fifo_cmd_t make_cmd(input logic [CMD_W-1:0] command,
			input logic [DATA_W-1:0] data, input logic [AMT_W-1:0] amount);
		fifo_cmd_t c;
		c.command = command;
		c.push_data = data;
		c.amount = amount;
		return c;
	endfunction

	// Mostly pushes and pulls, with offsets and skips kept near the held data.
	function automatic fifo_cmd_t random_command();
		fifo_cmd_t c;
		int cap;
		int held;
		int pick;
		cap = effective_capacity();
		held = ring_occupancy(cap);
		pick = $urandom_range(99);
		c.push_data = $urandom;
		c.amount = AMT_W'($urandom_range(255));
		if (pick < 38) begin
			c.command = CMD_PUSH;
		end else if (pick < 70) begin
			c.command = CMD_PULL;
		end else if (pick < 82) begin
			c.command = CMD_PEEK;
			if (pick < 79)
				c.amount = AMT_W'(held > 0 ? $urandom_range(held - 1) : $urandom_range(cap - 1));
		end else if (pick < 89) begin
			c.command = CMD_ADV_READ;
			if (pick < 87) c.amount = AMT_W'($urandom_range(held));
		end else if (pick < 95) begin
			c.command = CMD_ADV_WRIT;
			if (pick < 93) c.amount = AMT_W'($urandom_range(cap - 1 < 8 ? cap - 1 : 8));
		end else if (pick < 97) begin
			c.command = CMD_CLEAR;
		end else begin
			c.command = $urandom_range(1) ? CMD_RESERVED_6 : CMD_RESERVED_7;
		end
		return c;
	endfunction

	task automatic send_command(input fifo_cmd_t c);
		while (!no_idle && $urandom_range(99) < 35) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c.command;
		cmd_ch.push_data <= c.push_data;
		cmd_ch.amount <= c.amount;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_results.push_back(apply_command(c));
	endtask

	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The ring must be idle here; writing the register also empties it.
	task automatic set_capacity(input logic [CFG_DATA_W-1:0] value);
		wait_for_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		capacity_reg = value[CAP_W-1:0];
		read_ptr = 0;
		write_ptr = 0;
	endtask

	task automatic test_directed();
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		send_command(make_cmd(CMD_PUSH, 32'h0000_0000, 8'd0));
		send_command(make_cmd(CMD_PUSH, 32'hFFFF_FFFF, 8'd255));
		send_command(make_cmd(CMD_PUSH, 32'h5A5A_A5A5, 8'd0));
		send_command(make_cmd(CMD_PEEK, 32'h0, 8'd0));
		send_command(make_cmd(CMD_PEEK, 32'h0, 8'd2));
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		// An offset past the held data still reads the slot it lands on.
		send_command(make_cmd(CMD_PEEK, 32'h0, 8'd255));
		send_command(make_cmd(CMD_ADV_READ, 32'h0, 8'd0));
		send_command(make_cmd(CMD_ADV_WRIT, 32'h0, 8'd255));
		send_command(make_cmd(CMD_ADV_READ, 32'h0, 8'd255));
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		send_command(make_cmd(CMD_RESERVED_6, 32'hFFFF_FFFF, 8'd255));
		send_command(make_cmd(CMD_RESERVED_7, 32'h0, 8'd0));
		send_command(make_cmd(CMD_CLEAR, 32'h0, 8'd0));
		// A register value below the minimum gives the smallest ring.
		set_capacity(32'd0);
		send_command(make_cmd(CMD_PUSH, 32'h1234_5678, 8'd0));
		send_command(make_cmd(CMD_PUSH, 32'hDEAD_BEEF, 8'd0));
		send_command(make_cmd(CMD_PEEK, 32'h0, 8'd1));
		send_command(make_cmd(CMD_PEEK, 32'h0, 8'd2));
		send_command(make_cmd(CMD_ADV_READ, 32'h0, 8'd2));
		send_command(make_cmd(CMD_ADV_WRIT, 32'h0, 8'd255));
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		send_command(make_cmd(CMD_CLEAR, 32'h0, 8'd0));
	endtask

	// Fills the largest ring past full and drains it past empty while the
	// receiver holds off at first. Every slot of the store is written here,
	// so later reads never touch a slot that holds no element.
	task automatic test_fill_and_drain();
		set_capacity(32'd256);
		receiver_hold = 300;
		repeat (256) send_command(make_cmd(CMD_PUSH, $urandom, AMT_W'($urandom_range(255))));
		repeat (256) send_command(make_cmd(CMD_PULL, $urandom, AMT_W'($urandom_range(255))));
		send_command(make_cmd(CMD_PUSH, $urandom, 8'd0));
		send_command(make_cmd(CMD_PULL, 32'h0, 8'd0));
		wait_for_results();
	endtask

	task automatic test_random_phase(input logic [CFG_DATA_W-1:0] capacity, input int count);
		set_capacity(capacity);
		repeat (count) send_command(random_command());
	endtask

	always @(posedge clk) begin : check_results
		fifo_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result item with no command outstanding: data %h", res_ch.read_data);
			end else begin
				want = pending_results.pop_front();
				if (want.read_data !== res_ch.read_data)
					note_mismatch("read_data", want.read_data, res_ch.read_data);
				if (want.accepted !== res_ch.accepted)
					note_mismatch("accepted", want.accepted, res_ch.accepted);
				if (want.occupancy !== res_ch.occupancy)
					note_mismatch("occupancy", want.occupancy, res_ch.occupancy);
				if (want.free_slots !== res_ch.free_slots)
					note_mismatch("free_slots", want.free_slots, res_ch.free_slots);
				if (want.overflow_seen !== res_ch.overflow_seen)
					note_mismatch("overflow_seen", want.overflow_seen, res_ch.overflow_seen);
			end
		end
	end

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	// Receiver: random stalls unless no_idle is set, or one long hold-off when a test asks for it.
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (receiver_hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (receiver_hold) @(posedge clk);
				receiver_hold = 0;
			end
			res_ch.ready <= no_idle || ($urandom_range(99) >= 35);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** ring_fifo_with_peek: FAILED **");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_PUSH;
		cmd_ch.push_data <= '0;
		cmd_ch.amount <= '0;
		mismatch_count = 0;
		receiver_hold = 0;
		no_idle = 1'b0;
		read_ptr = 0;
		write_ptr = 0;
		overflow_flag = 1'b0;
		capacity_reg = CAP_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_phase(32'd2, 60);
		test_random_phase(32'd1, 60);
		test_random_phase(32'd3, 80);
		test_random_phase(32'd5, 80);
		test_random_phase(32'd256, 150);
		test_random_phase(32'd511, 150);
		no_idle = 1'b1;
		test_random_phase(32'd255, 100);
		no_idle = 1'b0;
		test_random_phase(32'd257, 80);
		repeat (3) test_random_phase($urandom_range(40, 4), 80);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("** ring_fifo_with_peek: PASSED **");
		end else begin
			$display("** ring_fifo_with_peek: FAILED **");
		end
		$finish;
	end

endmodule
